// File: hw/rtl/bpem_pkg.sv
// ----------------------------------------------------------------------------
// bpem_pkg - shared types and constants for the pair merge block
// Field widths, rule bank geometry and the types handed between cells.
// ----------------------------------------------------------------------------
package bpem_pkg;

  localparam int ID_W       = 11;                 // token id width
  localparam int IDX_W      = 10;                 // rule slot width
  localparam int CNT_W      = 11;                 // merge_count width
  localparam int RULES      = 1024;               // rule table depth
  localparam int BASE_VOCAB = 256;                // first merged id

  localparam int NCELL      = 4;                  // cells in the chain
  localparam int CELL_W     = $clog2(NCELL);
  localparam int BANK_DEPTH = RULES / NCELL;      // rules held per cell
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int IN_TDATA_W  = ((IDX_W + 3 * ID_W) + 7) / 8 * 8;
  localparam int OUT_TDATA_W = (ID_W + 7) / 8 * 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TOKEN = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
  } pair_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] rule;
  } hit_t;

endpackage

// File: hw/rtl/bpem_cell.sv
// ----------------------------------------------------------------------------
// bpem_cell - one rule bank cell of the match chain
// Holds every NCELL-th rule, reads one per cycle and compares it to the
// query pair; passes the lowest hit so far down to its neighbor.
// ----------------------------------------------------------------------------
module bpem_cell (
  input  logic                         clk,
  input  logic [bpem_pkg::CELL_W-1:0]  cell_idx,
  input  logic                         wr_en,
  input  logic [bpem_pkg::BANK_AW-1:0] wr_addr,
  input  bpem_pkg::pair_t              wr_data,
  input  logic                         rd_en,
  input  logic [bpem_pkg::BANK_AW-1:0] rd_addr,
  input  logic [bpem_pkg::BANK_AW-1:0] cmp_row,
  input  bpem_pkg::pair_t              query,
  input  logic [bpem_pkg::CNT_W-1:0]   limit,
  input  bpem_pkg::hit_t               hit_in,
  output bpem_pkg::hit_t               hit_out
);
  import bpem_pkg::*;

  pair_t             mem [BANK_DEPTH];
  pair_t             rdata_r;
  logic [IDX_W-1:0]  rule_num;
  logic              in_range;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rule_num = {cmp_row, cell_idx};
  assign in_range = CNT_W'(rule_num) < limit;

  // a hit from a lower cell wins; otherwise offer our own
  always_comb begin
    hit_out = hit_in;
    if (!hit_in.hit && in_range && (rdata_r == query)) begin
      hit_out.hit  = 1'b1;
      hit_out.rule = rule_num;
    end
  end

endmodule

// File: hw/rtl/bpe_single_pass_pair_merge.sv
// ----------------------------------------------------------------------------
// bpe_single_pass_pair_merge - single-pass byte pair merge over token segments
// Rule table load, rule search over a chain of bank cells, result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry either a rule load (in_tuser = 0) or a token
//   (in_tuser = 1, in_tlast marks the last token of a segment). A rule load
//   writes one pair into the table and gives no output beat.
//   A token with an id pending is paired with it and the rules 0 ..
//   merge_count-1 are searched; the lowest matching rule gives the merged
//   id BASE_VOCAB + rule. Each token produces zero, one or two output beats.
//   Rate: the table is split over NCELL cells that each read one rule per
//   cycle while a search runs, and the search stops at the first hit
//   within limit = min(merge_count, RULES); a token with nothing pending
//   skips the search and goes straight to the resolve step. A token is
//   done with before the next input beat is taken.
//   Results wait in a two-entry output queue; the next input beat is taken
//   while results still wait there. A stalled receiver holds the queue,
//   and a token waits in the resolve step until its results fit.
//   Reset (rst_n low, synchronous) clears merge_count, the pending id and
//   the queue; the rule table is not cleared and must be loaded.
//   cfg_wr_en writes merge_count at any clock edge; write it only when idle.
// ----------------------------------------------------------------------------
module bpe_single_pass_pair_merge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bpem_pkg::CNT_W-1:0]       cfg_wr_data,   // merge_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // rule_index[9:0], rule_first[20:10], rule_second[31:21], token_id[42:32]
  input  logic [bpem_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,      // command
  input  logic                             in_tlast,      // segment_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bpem_pkg::OUT_TDATA_W-1:0] out_tdata,     // out_id[10:0]
  output logic                             out_tlast      // out_last
);
  import bpem_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  // input field unpacking
  logic [IDX_W-1:0] f_rule_index;
  logic [ID_W-1:0]  f_rule_first;
  logic [ID_W-1:0]  f_rule_second;
  logic [ID_W-1:0]  f_token_id;

  assign f_rule_index  = in_tdata[IDX_W-1:0];
  assign f_rule_first  = in_tdata[IDX_W+ID_W-1:IDX_W];
  assign f_rule_second = in_tdata[IDX_W+2*ID_W-1:IDX_W+ID_W];
  assign f_token_id    = in_tdata[IDX_W+3*ID_W-1:IDX_W+2*ID_W];

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    merge_count_r;
  logic [ID_W-1:0]     held_id_r, held_id_nxt;
  logic                held_vld_r, held_vld_nxt;
  logic [ID_W-1:0]     tok_r, tok_nxt;
  logic                seg_r, seg_nxt;
  logic [BANK_AW:0]    row_r, row_nxt;        // next bank row to read
  logic                rd_vld_r, rd_vld_nxt;  // bank data valid this cycle
  logic [BANK_AW-1:0]  rd_row_r, rd_row_nxt;  // row the bank data came from
  hit_t                hit_r, hit_nxt;

  logic [ID_W-1:0]     q_id_r   [2];
  logic                q_last_r [2];
  logic [ID_W-1:0]     q_id_nxt   [2];
  logic                q_last_nxt [2];
  logic [1:0]          q_cnt_r, q_cnt_nxt;

  logic                in_acc;
  logic                pop;
  logic [CNT_W-1:0]    limit;
  logic                issue_ok;
  logic                rd_en;
  hit_t                chain [NCELL+1];
  pair_t               query;
  pair_t               wr_pair;

  // resolve step results
  logic [1:0]          res_n;
  logic [ID_W-1:0]     res_id0, res_id1;
  logic                res_last0;
  logic [1:0]          cnt_ap;   // queue depth after this cycle's pop
  logic                room;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {(OUT_TDATA_W-ID_W)'(0), q_id_r[0]};
  assign out_tlast  = q_last_r[0];
  assign pop        = out_tvalid && out_tready;

  // search no further than the table holds
  assign limit    = (merge_count_r > CNT_W'(RULES)) ? CNT_W'(RULES) : merge_count_r;
  assign issue_ok = CNT_W'({row_r, CELL_W'(0)}) < limit;
  assign rd_en    = (state_r == ST_SCAN) && issue_ok;
  assign query    = '{first: held_id_r, second: tok_r};
  assign wr_pair  = '{first: f_rule_first, second: f_rule_second};
  assign chain[0] = '0;

  // chain of bank cells: rule j lives in cell j mod NCELL, row j / NCELL
  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    bpem_cell u_cell (
      .clk      (clk),
      .cell_idx (CELL_W'(gi)),
      .wr_en    (in_acc && (in_tuser == CMD_LOAD) &&
                 (f_rule_index[CELL_W-1:0] == CELL_W'(gi))),
      .wr_addr  (f_rule_index[IDX_W-1:CELL_W]),
      .wr_data  (wr_pair),
      .rd_en    (rd_en),
      .rd_addr  (row_r[BANK_AW-1:0]),
      .cmp_row  (rd_row_r),
      .query    (query),
      .limit    (limit),
      .hit_in   (chain[gi]),
      .hit_out  (chain[gi+1])
    );
  end

  // work out what the pending token gives once the search is over
  always_comb begin
    res_n        = 2'd0;
    res_id0      = held_id_r;
    res_id1      = tok_r;
    res_last0    = 1'b0;
    held_id_nxt  = held_id_r;
    held_vld_nxt = held_vld_r;
    if (held_vld_r) begin
      if (hit_r.hit) begin
        // merge: the merged id closes the segment if this token does
        res_n        = 2'd1;
        res_id0      = ID_W'(BASE_VOCAB) + ID_W'(hit_r.rule);
        res_last0    = seg_r;
        held_id_nxt  = '0;
        held_vld_nxt = 1'b0;
      end else begin
        // no merge: emit the pending id, keep the new one (or emit it too at a segment end)
        res_n       = 2'd1;
        res_id0     = held_id_r;
        held_id_nxt = tok_r;
        if (seg_r) begin
          res_n        = 2'd2;
          held_id_nxt  = '0;
          held_vld_nxt = 1'b0;
        end
      end
    end else begin
      held_id_nxt  = tok_r;
      held_vld_nxt = 1'b1;
      if (seg_r) begin
        // flush the lone token at once
        res_n        = 2'd1;
        res_id0      = tok_r;
        res_last0    = 1'b1;
        held_id_nxt  = '0;
        held_vld_nxt = 1'b0;
      end
    end
  end

  assign cnt_ap = q_cnt_r - {1'b0, pop};
  assign room   = ({1'b0, cnt_ap} + {1'b0, res_n}) <= 3'd2;

  // control sequencing
  always_comb begin
    state_nxt  = state_r;
    tok_nxt    = tok_r;
    seg_nxt    = seg_r;
    row_nxt    = row_r;
    rd_vld_nxt = 1'b0;
    rd_row_nxt = rd_row_r;
    hit_nxt    = hit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == CMD_TOKEN)) begin
          tok_nxt   = f_token_id;
          seg_nxt   = in_tlast;
          row_nxt   = '0;
          hit_nxt   = '0;
          state_nxt = held_vld_r ? ST_SCAN : ST_RESOLVE;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = issue_ok;
        rd_row_nxt = row_r[BANK_AW-1:0];
        if (issue_ok) begin
          row_nxt = row_r + 1'b1;
        end
        if (rd_vld_r && chain[NCELL].hit) begin
          hit_nxt   = chain[NCELL];
          state_nxt = ST_RESOLVE;
        end else if (!issue_ok && !rd_vld_r) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (room) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output queue: slot 0 is on the port; shift on pop, append after it
  always_comb begin
    q_id_nxt[0]   = q_id_r[0];
    q_id_nxt[1]   = q_id_r[1];
    q_last_nxt[0] = q_last_r[0];
    q_last_nxt[1] = q_last_r[1];
    q_cnt_nxt     = cnt_ap;
    if (pop) begin
      q_id_nxt[0]   = q_id_r[1];
      q_last_nxt[0] = q_last_r[1];
    end
    if ((state_r == ST_RESOLVE) && room) begin
      q_cnt_nxt = cnt_ap + res_n;
      if (res_n != 2'd0) begin
        q_id_nxt[cnt_ap[0]]   = res_id0;
        q_last_nxt[cnt_ap[0]] = res_last0;
      end
      if (res_n == 2'd2) begin
        q_id_nxt[1]   = res_id1;
        q_last_nxt[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      merge_count_r <= '0;
      held_id_r     <= '0;
      held_vld_r    <= 1'b0;
      rd_vld_r      <= 1'b0;
      q_cnt_r       <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
      q_cnt_r  <= q_cnt_nxt;
      if (cfg_wr_en) begin
        merge_count_r <= cfg_wr_data;
      end
      if ((state_r == ST_RESOLVE) && room) begin
        held_id_r  <= held_id_nxt;
        held_vld_r <= held_vld_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    tok_r       <= tok_nxt;
    seg_r       <= seg_nxt;
    row_r       <= row_nxt;
    rd_row_r    <= rd_row_nxt;
    hit_r       <= hit_nxt;
    q_id_r[0]   <= q_id_nxt[0];
    q_id_r[1]   <= q_id_nxt[1];
    q_last_r[0] <= q_last_nxt[0];
    q_last_r[1] <= q_last_nxt[1];
  end

endmodule

// File: hw/rtl/bpem_checker.sv
// ----------------------------------------------------------------------------
// bpem_checker - port-level checks for the pair merge block
// Watches the top level's ports and flags protocol or sequencing slips.
// ----------------------------------------------------------------------------
module bpem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a rule load never makes a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("rule load produced an output beat");

  // a token beat starts a search or the resolve step, so the input side closes next cycle
  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input ready right after a token beat");

  // pad bits above the id stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:11] == 5'd0)
    else $error("output pad bits set");

endmodule

bind bpe_single_pass_pair_merge bpem_checker u_bpem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
